### rtl/cwmf_pkg.sv
// Shared types and constants of the cross-window median filter.
// Depends on nothing; imported by cwmf_median9 and cross_window_median_filter.
`default_nettype none

package cwmf_pkg;

    // Sizes and reset values of the configuration registers
    localparam int FRAME_WIDTH_W   = 11;
    localparam int FRAME_HEIGHT_W  = 13;
    localparam int CFG_DATA_W      = 13;
    localparam int CFG_IDX_W       = 1;
    localparam int FRAME_WIDTH_RST  = 1024;
    localparam int FRAME_HEIGHT_RST = 768;

    // Defaults for the top-level size parameters
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Lines kept in the line store (four past rows plus the current row)
    localparam int LINES = 5;
    // Values that enter one median
    localparam int TAPS  = 9;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [7:0] pixel_t;

    // One column of the vertical window; element k is the row k above the newest
    typedef pixel_t [LINES-1:0] column_t;

    // The nine values of one cross window
    typedef pixel_t [TAPS-1:0] cross_t;

    typedef struct packed {
        logic [7:0] pixel_in;
        logic       drain;
    } pixel_word_t;

    typedef struct packed {
        logic [7:0] median_out;
        logic       last_of_input;
        logic       last_of_frame;
    } result_word_t;

endpackage

`default_nettype wire

### rtl/cwmf_median9.sv
// Median of nine 8-bit values by parallel ranking.
// Depends on cwmf_pkg (pixel_t, cross_t, TAPS).
`default_nettype none

module cwmf_median9 (
    input  cwmf_pkg::cross_t vals,
    output cwmf_pkg::pixel_t median
);
    import cwmf_pkg::*;

    // Rank each value with ties broken by position; the value of rank four is
    // the median, and exactly one value has it.
    always_comb begin
        logic [3:0] rank;
        median = '0;
        for (int i = 0; i < TAPS; i++) begin
            rank = '0;
            for (int j = 0; j < TAPS; j++) begin
                if (j < i) begin
                    if (vals[j] <= vals[i]) rank = rank + 4'd1;
                end else if (j > i) begin
                    if (vals[j] < vals[i]) rank = rank + 4'd1;
                end
            end
            if (rank == 4'd4) median = median | vals[i];
        end
    end

endmodule

`default_nettype wire

### rtl/cross_window_median_filter.sv
// Top level of the cross-window median filter: line store, window, output register.
// Depends on cwmf_pkg and cwmf_median9.
//
// Usage:
//   s_ channel takes one word per gray pixel in raster order, frame_width per row
//   and frame_height rows per frame, then two rows of drain words. m_ channel
//   returns one median per pixel in raster order, lagging two rows and two
//   columns. The last word of a row yields up to three results; last_of_input
//   marks the final one, last_of_frame the bottom-right pixel of the frame.
//   A result reaches m_ through the input register, the window register and the
//   output register after the word that causes it is accepted.
//   Throughput: one word per clock while s_ready is high. The results at a row
//   end leave the output register one at a time, so s_ready drops while they
//   leave; the pace there is set by the single output register.
//   A configuration write (cfg_wr_en) drops s_ready for the next clock while
//   the position counters are brought inside the new frame size.
//   Reset (aresetn low, synchronous) clears the counters and pipeline valids
//   and loads the default frame size; the line store needs no clearing pass.
//   When m_ready is low the output word holds, and the input side keeps
//   accepting until the input and window stages are full.
`default_nettype none

module cross_window_median_filter #(
    parameter int MAX_WIDTH  = cwmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cwmf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [cwmf_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [cwmf_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  cwmf_pkg::pixel_word_t                s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output cwmf_pkg::result_word_t               m_data
);
    import cwmf_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH + 1);
    localparam int AW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW     = $clog2(MAX_HEIGHT + 2);
    localparam int RST_W  = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
    localparam int RST_H  = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;
    localparam int CENTER = 2;

    function automatic logic [2:0] inc5(input logic [2:0] v);
        return (v == 3'd4) ? 3'd0 : v + 3'd1;
    endfunction

    function automatic pixel_t pick_line(input column_t lines, input logic [2:0] sel);
        pixel_t p;
        case (sel)
            3'd0:    p = lines[0];
            3'd1:    p = lines[1];
            3'd2:    p = lines[2];
            3'd3:    p = lines[3];
            3'd4:    p = lines[4];
            default: p = lines[0];
        endcase
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Configuration: keep the effective (clamped) sizes
    // ------------------------------------------------------------------
    logic [CW-1:0] w_reg, wm1_reg;
    logic [RW-1:0] h_reg, hp1_reg;
    logic          renorm_reg;

    logic [FRAME_WIDTH_W-1:0]  cfg_w_raw;
    logic [FRAME_HEIGHT_W-1:0] cfg_h_raw;
    logic [CW-1:0]             cfg_w_eff;
    logic [RW-1:0]             cfg_h_eff;

    assign cfg_w_raw = cfg_wr_data[FRAME_WIDTH_W-1:0];
    assign cfg_h_raw = cfg_wr_data[FRAME_HEIGHT_W-1:0];

    // Zero acts as one; anything above the maximum acts as the maximum
    always_comb begin
        if (cfg_w_raw == '0) begin
            cfg_w_eff = CW'(1);
        end else if (32'(cfg_w_raw) > MAX_WIDTH) begin
            cfg_w_eff = CW'(MAX_WIDTH);
        end else begin
            cfg_w_eff = CW'(cfg_w_raw);
        end
        if (cfg_h_raw == '0) begin
            cfg_h_eff = RW'(1);
        end else if (32'(cfg_h_raw) > MAX_HEIGHT) begin
            cfg_h_eff = RW'(MAX_HEIGHT);
        end else begin
            cfg_h_eff = RW'(cfg_h_raw);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg      <= CW'(RST_W);
            wm1_reg    <= CW'(RST_W - 1);
            h_reg      <= RW'(RST_H);
            hp1_reg    <= RW'(RST_H + 1);
            renorm_reg <= 1'b0;
        end else begin
            // Re-fit the position counters to the new size on the next clock
            renorm_reg <= cfg_wr_en;
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_idx))
                    REG_FRAME_WIDTH: begin
                        w_reg   <= cfg_w_eff;
                        wm1_reg <= cfg_w_eff - CW'(1);
                    end
                    REG_FRAME_HEIGHT: begin
                        h_reg   <= cfg_h_eff;
                        hp1_reg <= cfg_h_eff + RW'(1);
                    end
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Position of the next input word; rm5_reg tracks row mod 5
    // ------------------------------------------------------------------
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [2:0]    rm5_reg, rm5_next;

    logic s_accept;
    logic col_end, col_is0, col_is1, col_ge2;
    logic row_lt_h, row_eq_h, row_eq_hp1, row_ge2;

    assign col_end    = (col_reg == wm1_reg);
    assign col_is0    = (col_reg == '0);
    assign col_is1    = (col_reg == CW'(1));
    assign col_ge2    = (32'(col_reg) >= 2);
    assign row_lt_h   = (row_reg < h_reg);
    assign row_eq_h   = (row_reg == h_reg);
    assign row_eq_hp1 = (row_reg == hp1_reg);
    assign row_ge2    = (32'(row_reg) >= 2);

    always_comb begin
        logic [RW:0] row_t;
        logic [2:0]  rm_t;
        col_next = col_reg;
        row_next = row_reg;
        rm5_next = rm5_reg;
        row_t    = {1'b0, row_reg};
        rm_t     = rm5_reg;
        if (renorm_reg) begin
            // Column past the row end starts the next row; row past the
            // drain rows starts a new frame
            if (col_reg >= w_reg) begin
                col_next = '0;
                row_t    = row_t + (RW+1)'(1);
                rm_t     = inc5(rm_t);
            end
            if (row_t > {1'b0, hp1_reg}) begin
                row_t = '0;
                rm_t  = '0;
            end
            row_next = row_t[RW-1:0];
            rm5_next = rm_t;
        end else if (s_accept) begin
            if (col_end) begin
                col_next = '0;
                if (row_eq_hp1) begin
                    row_next = '0;
                    rm5_next = '0;
                end else begin
                    row_next = row_reg + RW'(1);
                    rm5_next = inc5(rm5_reg);
                end
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Line select for rows r..r-4, clamped to the frame. Row r-k maps to
    // row r-k' with k' = max(min(k, r), r-h+1); the line is (r - k') mod 5.
    // k' = 0 is the row being written now: take the incoming pixel.
    // ------------------------------------------------------------------
    logic [LINES-1:0][2:0] a_sel_next;
    logic [LINES-1:0]      a_byp_next;

    always_comb begin
        logic [2:0] e;
        logic [2:0] kc;
        logic [2:0] kp;
        e = row_eq_h ? 3'd1 : (row_eq_hp1 ? 3'd2 : 3'd0);
        for (int k = 0; k < LINES; k++) begin
            if (32'(row_reg) < k) kc = 3'(row_reg);
            else                  kc = 3'(k);
            kp = (kc > e) ? kc : e;
            if (rm5_reg >= kp) a_sel_next[k] = rm5_reg - kp;
            else               a_sel_next[k] = rm5_reg + 3'd5 - kp;
            a_byp_next[k] = (kp == 3'd0);
        end
    end

    // Results this word causes: one past column 1, and at a row end all
    // remaining columns of the output row
    logic [1:0] a_cnt_next;

    always_comb begin
        if (!row_ge2) begin
            a_cnt_next = 2'd0;
        end else if (col_end) begin
            a_cnt_next = col_is0 ? 2'd1 : (col_is1 ? 2'd2 : 2'd3);
        end else begin
            a_cnt_next = col_ge2 ? 2'd1 : 2'd0;
        end
    end

    pixel_t in_pix;
    assign in_pix = s_data.drain ? 8'd0 : s_data.pixel_in;

    // ------------------------------------------------------------------
    // Line store: five single-port-write, single-port-read lines
    // ------------------------------------------------------------------
    column_t rd_data;

    for (genvar gk = 0; gk < LINES; gk++) begin : g_line
        pixel_t line_mem [MAX_WIDTH];
        pixel_t rd_reg;

        always_ff @(posedge aclk) begin
            if (s_accept && row_lt_h && (rm5_reg == 3'(gk))) begin
                line_mem[col_reg[AW-1:0]] <= in_pix;
            end
            if (s_accept) begin
                rd_reg <= line_mem[col_reg[AW-1:0]];
            end
        end

        assign rd_data[gk] = rd_reg;
    end

    // ------------------------------------------------------------------
    // Input stage, window stage, output register
    // ------------------------------------------------------------------
    logic                  a_valid_reg;
    pixel_t                a_pix_reg;
    logic [LINES-1:0]      a_byp_reg;
    logic [LINES-1:0][2:0] a_sel_reg;
    logic [1:0]            a_cnt_reg;
    logic                  a_col0_reg, a_dbl_reg, a_lof_reg;

    logic [1:0]   b_cnt_reg, b_cnt_next;
    logic         b_lof_reg, b_lof_next;
    column_t [4:0] win_reg, win_next;

    logic         m_valid_reg;
    result_word_t m_data_reg;

    logic    m_load, b_take;
    column_t new_col;
    cross_t  cross_vals;
    pixel_t  med;

    assign m_load   = (b_cnt_reg != 2'd0) && (!m_valid_reg || m_ready);
    assign b_take   = a_valid_reg && ((b_cnt_reg == 2'd0) || ((b_cnt_reg == 2'd1) && m_load));
    assign s_ready  = !renorm_reg && (!a_valid_reg || b_take);
    assign s_accept = s_valid && s_ready;

    always_comb begin
        for (int k = 0; k < LINES; k++) begin
            new_col[k] = a_byp_reg[k] ? a_pix_reg : pick_line(rd_data, a_sel_reg[k]);
        end
    end

    // Window: entry 0 is the newest column. A row start replicates column 0
    // to the left; a row end replicates the last column to the right.
    always_comb begin
        win_next   = win_reg;
        b_cnt_next = b_cnt_reg;
        b_lof_next = b_lof_reg;
        if (b_take) begin
            b_cnt_next = a_cnt_reg;
            b_lof_next = a_lof_reg;
            if (a_col0_reg) begin
                for (int j = 0; j < 5; j++) win_next[j] = new_col;
            end else if (a_dbl_reg) begin
                win_next[0] = new_col;
                win_next[1] = new_col;
                for (int j = 2; j < 5; j++) win_next[j] = win_reg[j-2];
            end else begin
                win_next[0] = new_col;
                for (int j = 1; j < 5; j++) win_next[j] = win_reg[j-1];
            end
        end else if (m_load) begin
            b_cnt_next = b_cnt_reg - 2'd1;
            if (b_cnt_reg != 2'd1) begin
                // Advance to the next column of the row end
                win_next[0] = win_reg[0];
                for (int j = 1; j < 5; j++) win_next[j] = win_reg[j-1];
            end
        end
    end

    // Cross: the center column vertically, the center row horizontally
    always_comb begin
        for (int k = 0; k < LINES; k++) cross_vals[k] = win_reg[CENTER][k];
        cross_vals[5] = win_reg[0][CENTER];
        cross_vals[6] = win_reg[1][CENTER];
        cross_vals[7] = win_reg[3][CENTER];
        cross_vals[8] = win_reg[4][CENTER];
    end

    cwmf_median9 u_median (
        .vals   (cross_vals),
        .median (med)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            rm5_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_cnt_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            rm5_reg   <= rm5_next;
            b_cnt_reg <= b_cnt_next;
            if (s_accept) begin
                a_valid_reg <= 1'b1;
            end else if (b_take) begin
                a_valid_reg <= 1'b0;
            end
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_pix_reg  <= in_pix;
            a_byp_reg  <= a_byp_next;
            a_sel_reg  <= a_sel_next;
            a_cnt_reg  <= a_cnt_next;
            a_col0_reg <= col_is0;
            a_dbl_reg  <= col_end && col_is1;
            a_lof_reg  <= col_end && row_eq_hp1;
        end
        win_reg   <= win_next;
        b_lof_reg <= b_lof_next;
        if (m_load) begin
            m_data_reg.median_out    <= med;
            m_data_reg.last_of_input <= (b_cnt_reg == 2'd1);
            m_data_reg.last_of_frame <= (b_cnt_reg == 2'd1) && b_lof_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Outside the re-fit clock the position lies inside the frame
    a_pos_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        !renorm_reg |-> (col_reg < w_reg) && (row_reg <= hp1_reg))
        else $error("position counters outside the frame");

    // The frame end is always the last result of its word
    a_lof_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.last_of_frame |-> m_data_reg.last_of_input)
        else $error("frame end marked on a result that is not the last");

    // Results of one word leave back to back once the receiver takes them
    a_row_end_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_ready && !m_data_reg.last_of_input |=> m_valid_reg)
        else $error("gap inside the results of one word");

endmodule

`default_nettype wire

### sim/cross_window_median_filter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for cross_window_median_filter: directed and random frames,
// predicted word by word and compared field by field. Depends on cwmf_pkg and the RTL.

module cross_window_median_filter_tb;

    import cwmf_pkg::*;

    localparam int MAX_W      = DEF_MAX_WIDTH;
    localparam int MAX_H      = DEF_MAX_HEIGHT;
    localparam int TIMEOUT_CYC = 1_000_000;
    localparam int SETTLE_CYC  = 8;       // clocks of settling after the pipeline has emptied
    localparam int PHASE_WORDS = 30;      // minimum random input words per pacing mode

    // Cross window taps: centre, row neighbors at +-1/+-2, then column neighbors.
    localparam int COL_STEP [TAPS] = '{0, -1, 1, -2, 2, 0, 0, 0, 0};
    localparam int ROW_STEP [TAPS] = '{0, 0, 0, 0, 0, -1, 1, -2, 2};

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    pixel_word_t  s_data = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    result_word_t m_data;

    cross_window_median_filter dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_idx     (cfg_idx),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: its own line store, raster position and size regs
    // ------------------------------------------------------------------
    pixel_t       line_mem [LINES][MAX_W];
    int           in_col = 0;
    int           in_row = 0;
    int unsigned  width_reg  = FRAME_WIDTH_RST;
    int unsigned  height_reg = FRAME_HEIGHT_RST;

    pixel_word_t  pending_pixels [$];     // words waiting for the driver
    result_word_t expected_medians [$];   // medians predicted, not yet seen on m_

    int unsigned  send_idle_pct  = 0;     // chance per cycle that the sender holds off
    int unsigned  recv_stall_pct = 0;     // chance per cycle that m_ready is low
    int unsigned  mismatch_count = 0;
    int unsigned  clock_count    = 0;

    // Register value as the block uses it: zero acts as one, big values saturate.
    function automatic int clamp_size(int unsigned value, int unsigned limit);
        if (value == 0) return 1;
        if (value > limit) return limit;
        return value;
    endfunction

    // Median of the nine cross taps around (r,c), edges replicated.
    function automatic pixel_t cross_median(int r, int c, int w, int h);
        pixel_t v [TAPS];
        pixel_t t;
        int rr;
        int cc;
        for (int i = 0; i < TAPS; i++) begin
            rr = r + ROW_STEP[i];
            cc = c + COL_STEP[i];
            if (rr < 0) rr = 0;
            else if (rr > h - 1) rr = h - 1;
            if (cc < 0) cc = 0;
            else if (cc > w - 1) cc = w - 1;
            v[i] = line_mem[rr % LINES][cc];
        end
        for (int i = 0; i < TAPS - 1; i++) begin
            for (int j = 0; j < TAPS - 1 - i; j++) begin
                if (v[j] > v[j + 1]) begin
                    t = v[j];
                    v[j] = v[j + 1];
                    v[j + 1] = t;
                end
            end
        end
        return v[TAPS / 2];
    endfunction

    // Advance the predictor by one accepted word and queue the medians it releases.
    function automatic void predict_medians(pixel_word_t word);
        int w;
        int h;
        int row;
        int col;
        int lo;
        int hi;
        int c;
        bit any;
        result_word_t res;
        w = clamp_size(width_reg, MAX_W);
        h = clamp_size(height_reg, MAX_H);
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (in_row >= h + 2) in_row = 0;
        row = in_row;
        col = in_col;
        // Row position decides what a word is; the drain flag only zeroes a pixel.
        if (row < h) line_mem[row % LINES][col] = word.drain ? 8'd0 : word.pixel_in;
        if (row >= 2) begin
            any = 1'b1;
            lo = 0;
            if (col >= 2) lo = col - 2;
            else if (col != w - 1) any = 1'b0;
            hi = (col == w - 1) ? w - 1 : col - 2;
            if (any) begin
                for (c = lo; c <= hi; c++) begin
                    res.median_out    = cross_median(row - 2, c, w, h);
                    res.last_of_input = (c == hi);
                    res.last_of_frame = (row - 2 == h - 1) && (c == w - 1);
                    expected_medians.push_back(res);
                end
            end
        end
        in_col = col + 1;
        if (in_col >= w) begin
            in_col = 0;
            in_row = row + 1;
            if (in_row >= h + 2) in_row = 0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and watchdog
    // ------------------------------------------------------------------
    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        clock_count <= clock_count + 1;
        if (clock_count > TIMEOUT_CYC) begin
            $display("Timeout after %0d cycles, %0d words pending, %0d medians expected",
                     clock_count, pending_pixels.size(), expected_medians.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: predict on each accepted word, then offer the next one
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // s_data still holds the word taken at this edge
            if (s_valid && s_ready) predict_medians(s_data);
            // Hold valid and payload until the word is taken; only refill a free slot.
            if (!s_valid || s_ready) begin
                if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data  <= pending_pixels.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result word with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        result_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_medians.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result word, expected none, got %h",
                             $time, m_data);
                end else begin
                    want = expected_medians.pop_front();
                    if (m_data.median_out !== want.median_out) begin
                        mismatch_count++;
                        $display("%0t: median_out expected %0d, got %0d",
                                 $time, want.median_out, m_data.median_out);
                    end
                    if (m_data.last_of_input !== want.last_of_input) begin
                        mismatch_count++;
                        $display("%0t: last_of_input expected %b, got %b",
                                 $time, want.last_of_input, m_data.last_of_input);
                    end
                    if (m_data.last_of_frame !== want.last_of_frame) begin
                        mismatch_count++;
                        $display("%0t: last_of_frame expected %b, got %b",
                                 $time, want.last_of_frame, m_data.last_of_frame);
                    end
                end
            end
            // Draw a fresh stall decision every cycle.
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_word(logic [7:0] pix, logic drn);
        pixel_word_t word;
        word.pixel_in = pix;
        word.drain    = drn;
        pending_pixels.push_back(word);
    endfunction

    // Write one size register; the predictor copy follows at the same edge.
    task automatic write_size_reg(cfg_reg_t idx, int unsigned value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_idx     <= idx;
        cfg_wr_data <= value[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        if (idx == REG_FRAME_WIDTH) width_reg = value & ((1 << FRAME_WIDTH_W) - 1);
        else height_reg = value & ((1 << FRAME_HEIGHT_W) - 1);
    endtask

    task automatic set_frame_size(int unsigned w, int unsigned h);
        write_size_reg(REG_FRAME_WIDTH, w);
        write_size_reg(REG_FRAME_HEIGHT, h);
    endtask

    // Queue one well-formed frame (pixel rows then two drain rows) with random
    // content, a few stray drain flags in pixel rows and some cleared flags in
    // the drain rows. Returns the number of words queued.
    function automatic int queue_random_frame();
        int w;
        int h;
        logic [7:0] pix;
        w = clamp_size(width_reg, MAX_W);
        h = clamp_size(height_reg, MAX_H);
        for (int r = 0; r < h + 2; r++) begin
            for (int c = 0; c < w; c++) begin
                if ($urandom_range(9) == 0) pix = $urandom_range(1) ? 8'hFF : 8'h00;
                else pix = $urandom_range(255);
                if (r < h) queue_word(pix, $urandom_range(7) == 0);
                else queue_word(pix, $urandom_range(3) != 0);
            end
        end
        return w * (h + 2);
    endfunction

    // Pause the sender until every word is taken and every median has come
    // back, then let the pipeline settle before the next register write.
    // Check on the falling edge so the driver's updates have landed.
    task automatic drain_pipeline();
        while (pending_pixels.size() != 0 || s_valid || expected_medians.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned stall_modes [4][2];
        int unsigned phase_words;
        int unsigned w_pick;
        int unsigned h_pick;

        stall_modes = '{'{0, 0}, '{71, 0}, '{0, 71}, '{19, 19}};
        while (!aresetn) @(posedge aclk);

        // Directed: 2x2 frame with extreme pixels, a drain flag inside a pixel row
        // (stored as zero) and a cleared drain flag inside a drain row.
        set_frame_size(2, 2);
        queue_word(8'hFF, 1'b0);
        queue_word(8'h00, 1'b0);
        queue_word(8'hFF, 1'b1);
        queue_word(8'h80, 1'b0);
        queue_word(8'h00, 1'b1);
        queue_word(8'h4D, 1'b0);
        queue_word(8'hFF, 1'b1);
        queue_word(8'h00, 1'b1);
        drain_pipeline();

        // Directed: 4 wide, one row; the last row end releases three medians.
        set_frame_size(4, 1);
        queue_word(8'hFF, 1'b0);
        queue_word(8'h01, 1'b0);
        queue_word(8'hFE, 1'b0);
        queue_word(8'h00, 1'b0);
        queue_word(8'h00, 1'b1);
        queue_word(8'hFF, 1'b0);
        queue_word(8'h00, 1'b1);
        queue_word(8'h00, 1'b1);
        queue_word(8'h80, 1'b1);
        queue_word(8'h00, 1'b1);
        queue_word(8'h00, 1'b0);
        queue_word(8'h00, 1'b1);
        drain_pipeline();

        // Directed: single-column frame, every row end from row 2 on yields just one median.
        set_frame_size(1, 3);
        queue_word(8'hFF, 1'b0);
        queue_word(8'h00, 1'b0);
        queue_word(8'hFF, 1'b0);
        queue_word(8'h00, 1'b1);
        queue_word(8'hAA, 1'b0);
        drain_pipeline();

        // Random small frames under each pacing mode; one or two frames may run
        // back to back on one setting to cover the frame wrap.
        for (int m = 0; m < 4; m++) begin
            send_idle_pct  = stall_modes[m][0];
            recv_stall_pct = stall_modes[m][1];
            phase_words = 0;
            while (phase_words < PHASE_WORDS) begin
                if ($urandom_range(4) == 0) begin
                    w_pick = $urandom_range(13, 40);
                    h_pick = $urandom_range(0, 2);
                end else begin
                    w_pick = $urandom_range(0, 12);
                    h_pick = $urandom_range(0, 7);
                end
                set_frame_size(w_pick, h_pick);
                repeat ($urandom_range(1, 2)) phase_words += queue_random_frame();
                drain_pipeline();
            end
        end

        drain_pipeline();
        if (expected_medians.size() != 0) begin
            mismatch_count++;
            $display("%0t: %0d expected medians never arrived", $time, expected_medians.size());
        end
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### cross_window_median_filter.f
rtl/cwmf_pkg.sv
rtl/cwmf_median9.sv
rtl/cross_window_median_filter.sv
sim/cross_window_median_filter_tb.sv
